>>> sv/lpf_pkg.sv
// Shared types, constants and helpers for the lidar point filter.
// No dependencies; every other file imports this package.
package lpf_pkg;

  localparam int COORD_BITS     = 24;
  localparam int SQ_BITS        = 2 * COORD_BITS;
  localparam int SUM_BITS       = SQ_BITS + 2;
  localparam int LINE_BITS      = 7;
  localparam int KEEP_BITS      = 8;
  localparam int BLIND_BITS     = 16;
  localparam int BLIND_SQ_BITS  = 2 * BLIND_BITS;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int COUNT_BITS     = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LINE_COUNT = 2'd0,
    CFG_KEEP_EVERY = 2'd1,
    CFG_BLIND_MM   = 2'd2
  } cfg_reg_t;

  localparam logic [LINE_BITS-1:0]  LINE_COUNT_RST = 7'd4;
  localparam logic [KEEP_BITS-1:0]  KEEP_EVERY_RST = 8'd1;
  localparam logic [BLIND_BITS-1:0] BLIND_MM_RST   = 16'd500;

  localparam logic [7:0] TAG_QUAL_MASK = 8'h30;
  localparam logic [7:0] TAG_QUAL_LOW  = 8'h10;
  localparam logic [7:0] TAG_QUAL_NONE = 8'h00;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  function automatic logic [COORD_BITS-1:0] coord_mag(input coord_t v);
    logic [COORD_BITS-1:0] u;
    u = v;
    return u[COORD_BITS-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

>>> sv/lpf_if.sv
// Valid/ready channel interfaces for point items and result items.
// Depends on lpf_pkg.
interface lpf_in_if import lpf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          frame_start;
  coord_t        point_x;
  coord_t        point_y;
  coord_t        point_z;
  logic [7:0]    scan_line;
  logic [7:0]    quality_tag;
  logic [7:0]    reflectivity;
  logic [31:0]   offset_ns;

  modport source (output valid, frame_start, point_x, point_y, point_z, scan_line,
                  quality_tag, reflectivity, offset_ns, input ready);
  modport sink   (input valid, frame_start, point_x, point_y, point_z, scan_line,
                  quality_tag, reflectivity, offset_ns, output ready);
endinterface

interface lpf_out_if import lpf_pkg::*; ();
  logic          valid;
  logic          ready;
  coord_t        out_x;
  coord_t        out_y;
  coord_t        out_z;
  logic [7:0]    out_intensity;
  logic [31:0]   out_time_ns;
  logic [31:0]   kept_index;

  modport source (output valid, out_x, out_y, out_z, out_intensity, out_time_ns,
                  kept_index, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_intensity, out_time_ns,
                  kept_index, output ready);
endinterface

>>> sv/lpf_range.sv
// Blind-range test: registered squares of the coordinate magnitudes, then
// sum and compare against the squared blind distance. Depends on lpf_pkg.
module lpf_range import lpf_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  point_t                pt,
  input  logic [BLIND_BITS-1:0] blind_mm,
  output logic                  far
);

  logic [COORD_BITS-1:0]    mag_x, mag_y, mag_z;
  logic [SQ_BITS-1:0]       sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_BITS-1:0]       sq_x_nxt, sq_y_nxt, sq_z_nxt;
  logic [BLIND_SQ_BITS-1:0] blind_sq_r, blind_sq_nxt;
  logic [SUM_BITS-1:0]      dist_sq;

  always_comb begin
    mag_x        = coord_mag(pt.x);
    mag_y        = coord_mag(pt.y);
    mag_z        = coord_mag(pt.z);
    sq_x_nxt     = SQ_BITS'(mag_x) * SQ_BITS'(mag_x);
    sq_y_nxt     = SQ_BITS'(mag_y) * SQ_BITS'(mag_y);
    sq_z_nxt     = SQ_BITS'(mag_z) * SQ_BITS'(mag_z);
    blind_sq_nxt = BLIND_SQ_BITS'(blind_mm) * BLIND_SQ_BITS'(blind_mm);
  end

  always_ff @(posedge clk) begin
    blind_sq_r <= blind_sq_nxt;
    if (en) begin
      sq_x_r <= sq_x_nxt;
      sq_y_r <= sq_y_nxt;
      sq_z_r <= sq_z_nxt;
    end
  end

  assign dist_sq = SUM_BITS'(sq_x_r) + SUM_BITS'(sq_y_r) + SUM_BITS'(sq_z_r);
  assign far     = dist_sq > SUM_BITS'(blind_sq_r);

endmodule

>>> sv/lidar_point_filter_unit.sv
// Lidar point filter top level: config registers, input stage, decision
// stage with frame state, output register. Depends on lpf_pkg, lpf_if, lpf_range.
//
// Usage:
//   in_ch  : one lidar point per item (valid/ready). frame_start clears the
//            frame state; that item is dropped.
//   out_ch : zero or one result item per point: coordinates, intensity, time
//            and kept_index (points kept earlier in the frame).
//   cfg_*  : write port; cfg_we writes cfg_wdata to register cfg_index
//            (0 line_count, 1 keep_every, 2 blind_mm). Write only while idle.
//   Path: a kept point passes the input and decision stages to out_ch; one item
//   per cycle unless out_ch stalls. The decision stage reads and updates the
//   frame state (sample phase, last kept point, kept count) in the same cycle.
//   Reset (rst_n low, synchronous): registers return to 4 / 1 / 500, the frame
//   state clears and the pipeline empties.
//   Stall: while out_ch holds an untaken result the decision stage waits;
//   empty slots ahead of it still take new items, then in_ch.ready drops.
module lidar_point_filter_unit import lpf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  lpf_in_if.sink                   in_ch,
  lpf_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // configuration
  logic [LINE_BITS-1:0]  line_count_r;
  logic [KEEP_BITS-1:0]  keep_every_r;
  logic [BLIND_BITS-1:0] blind_mm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= LINE_COUNT_RST;
      keep_every_r <= KEEP_EVERY_RST;
      blind_mm_r   <= BLIND_MM_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LINE_COUNT: line_count_r <= cfg_wdata[LINE_BITS-1:0];
        CFG_KEEP_EVERY: keep_every_r <= cfg_wdata[KEEP_BITS-1:0];
        CFG_BLIND_MM:   blind_mm_r   <= cfg_wdata[BLIND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_go, s1_adv, s2_fire;

  assign out_go      = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s2_valid_r || out_go;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign s2_fire     = s2_valid_r && out_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_adv)      s2_valid_r <= s1_valid_r;
    end
  end

  // input stage
  logic        s1_frame_r;
  point_t      s1_pt_r;
  logic [7:0]  s1_line_r, s1_tag_r, s1_refl_r;
  logic [31:0] s1_time_r;

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_frame_r <= in_ch.frame_start;
      s1_pt_r    <= '{x: in_ch.point_x, y: in_ch.point_y, z: in_ch.point_z};
      s1_line_r  <= in_ch.scan_line;
      s1_tag_r   <= in_ch.quality_tag;
      s1_refl_r  <= in_ch.reflectivity;
      s1_time_r  <= in_ch.offset_ns;
    end
  end

  // decision stage
  logic        s2_frame_r;
  point_t      s2_pt_r;
  logic [7:0]  s2_line_r, s2_tag_r, s2_refl_r;
  logic [31:0] s2_time_r;
  logic        s2_far;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_frame_r <= s1_frame_r;
      s2_pt_r    <= s1_pt_r;
      s2_line_r  <= s1_line_r;
      s2_tag_r   <= s1_tag_r;
      s2_refl_r  <= s1_refl_r;
      s2_time_r  <= s1_time_r;
    end
  end

  lpf_range u_range (
    .clk      (clk),
    .en       (s1_adv),
    .pt       (s1_pt_r),
    .blind_mm (blind_mm_r),
    .far      (s2_far)
  );

  // frame state
  logic [KEEP_BITS-1:0]  phase_r, phase_nxt;
  point_t                last_r, last_nxt;
  logic                  have_last_r, have_last_nxt;
  logic [COUNT_BITS-1:0] kept_count_r, kept_count_nxt;

  logic                 line_ok, tag_ok, valid_pt, sampled, dup, keep;
  logic [KEEP_BITS-1:0] keep_n;
  logic [KEEP_BITS:0]   phase_inc;
  logic [7:0]           tag_qual;

  always_comb begin
    tag_qual  = s2_tag_r & TAG_QUAL_MASK;
    line_ok   = s2_line_r < {1'b0, line_count_r};
    tag_ok    = (tag_qual == TAG_QUAL_LOW) || (tag_qual == TAG_QUAL_NONE);
    valid_pt  = !s2_frame_r && line_ok && tag_ok;
    keep_n    = (keep_every_r == '0) ? KEEP_BITS'(1) : keep_every_r;
    phase_inc = {1'b0, phase_r} + 1'b1;
    sampled   = phase_inc >= {1'b0, keep_n};
    dup       = have_last_r && (s2_pt_r == last_r);
    keep      = valid_pt && sampled && s2_far && !dup;

    phase_nxt      = phase_r;
    last_nxt       = last_r;
    have_last_nxt  = have_last_r;
    kept_count_nxt = kept_count_r;
    if (s2_fire) begin
      if (s2_frame_r) begin
        phase_nxt      = '0;
        last_nxt       = '0;
        have_last_nxt  = 1'b0;
        kept_count_nxt = '0;
      end else if (valid_pt) begin
        phase_nxt = sampled ? '0 : phase_inc[KEEP_BITS-1:0];
        if (keep) begin
          last_nxt       = s2_pt_r;
          have_last_nxt  = 1'b1;
          kept_count_nxt = kept_count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      last_r       <= '0;
      have_last_r  <= 1'b0;
      kept_count_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      last_r       <= last_nxt;
      have_last_r  <= have_last_nxt;
      kept_count_r <= kept_count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_go) begin
      out_valid_r <= s2_valid_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && keep) begin
      out_ch.out_x         <= s2_pt_r.x;
      out_ch.out_y         <= s2_pt_r.y;
      out_ch.out_z         <= s2_pt_r.z;
      out_ch.out_intensity <= s2_refl_r;
      out_ch.out_time_ns   <= s2_time_r;
      out_ch.kept_index    <= kept_count_r;
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != {KEEP_BITS{1'b1}})
    else $error("sample phase out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && keep) |=> kept_count_r == $past(kept_count_r) + 32'd1)
    else $error("kept count did not step on a kept item");

  a_no_last_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    !have_last_r |-> kept_count_r == '0)
    else $error("kept count nonzero without a last kept point");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(kept_count_r) && $stable(phase_r))
    else $error("frame state moved while output stalled");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for lidar_point_filter_unit: directed and random point
// streams, a behavioral filter predictor and an in-order result check.
// Depends on lpf_pkg, lpf_if and the RTL under sv/.
module tb_top;
  import lpf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 40;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic        frame_start;
    point_t      pos;
    logic [7:0]  line;
    logic [7:0]  tag;
    logic [7:0]  refl;
    logic [31:0] offs;
  } pt_item_t;

  typedef struct {
    point_t      pos;
    logic [7:0]  intensity;
    logic [31:0] time_ns;
    logic [31:0] index;
  } kept_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_fire = 1'b0;
  logic steady = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  lpf_in_if  in_ch ();
  lpf_out_if out_ch ();

  lidar_point_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pt_item_t point_backlog[$];
  kept_pt_t kept_due[$];
  int       errors = 0;
  int       cycles = 0;

  // filter model state
  logic [LINE_BITS-1:0]  line_cfg  = LINE_COUNT_RST;
  logic [KEEP_BITS-1:0]  keep_cfg  = KEEP_EVERY_RST;
  logic [BLIND_BITS-1:0] blind_cfg = BLIND_MM_RST;
  logic [8:0]            sample_phase = '0;
  point_t                last_kept = '0;
  logic                  have_last = 1'b0;
  logic [31:0]           kept_cnt = '0;

  point_t   prev_pos = '0;
  kept_pt_t want;
  pt_item_t seen;

  task automatic clear_frame();
    sample_phase = '0;
    last_kept    = '0;
    have_last    = 1'b0;
    kept_cnt     = '0;
  endtask

  function automatic longint coord_sq(input coord_t c);
    longint v;
    v = longint'(c);
    return v * v;
  endfunction

  task automatic filter_point(input pt_item_t p);
    logic [8:0] n;
    longint     dist_sq;
    longint     blind_sq;
    kept_pt_t   r;
    if (p.frame_start) begin
      clear_frame();
      return;
    end
    if (p.line >= {1'b0, line_cfg}) return;
    if ((p.tag & TAG_QUAL_MASK) != TAG_QUAL_LOW &&
        (p.tag & TAG_QUAL_MASK) != TAG_QUAL_NONE) return;
    n = (keep_cfg == '0) ? 9'd1 : {1'b0, keep_cfg};
    sample_phase = sample_phase + 9'd1;
    if (sample_phase < n) return;
    sample_phase = '0;
    dist_sq = coord_sq(p.pos.x) + coord_sq(p.pos.y) + coord_sq(p.pos.z);
    blind_sq = longint'(blind_cfg) * longint'(blind_cfg);
    if (dist_sq <= blind_sq) return;
    if (have_last && p.pos == last_kept) return;
    r.pos       = p.pos;
    r.intensity = p.refl;
    r.time_ns   = p.offs;
    r.index     = kept_cnt;
    kept_due = {kept_due, r};
    kept_cnt  = kept_cnt + 32'd1;
    last_kept = p.pos;
    have_last = 1'b1;
  endtask

  task automatic flag_mismatch(input string msg);
    if (errors < PRINT_LIMIT)
      $display("tb_top: mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (point_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
        seen = point_backlog.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.frame_start  <= seen.frame_start;
        in_ch.point_x      <= seen.pos.x;
        in_ch.point_y      <= seen.pos.y;
        in_ch.point_z      <= seen.pos.z;
        in_ch.scan_line    <= seen.line;
        in_ch.quality_tag  <= seen.tag;
        in_ch.reflectivity <= seen.refl;
        in_ch.offset_ns    <= seen.offs;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= 21);
  end

  // accepted points feed the predictor
  always @(posedge clk) begin
    pt_item_t p;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.frame_start = in_ch.frame_start;
      p.pos.x       = in_ch.point_x;
      p.pos.y       = in_ch.point_y;
      p.pos.z       = in_ch.point_z;
      p.line        = in_ch.scan_line;
      p.tag         = in_ch.quality_tag;
      p.refl        = in_ch.reflectivity;
      p.offs        = in_ch.offset_ns;
      filter_point(p);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (kept_due.size() == 0) begin
        flag_mismatch("result with nothing pending");
      end else begin
        want = kept_due.pop_front();
        if (out_ch.out_x !== want.pos.x)
          flag_mismatch($sformatf("out_x %0d, want %0d", out_ch.out_x, want.pos.x));
        if (out_ch.out_y !== want.pos.y)
          flag_mismatch($sformatf("out_y %0d, want %0d", out_ch.out_y, want.pos.y));
        if (out_ch.out_z !== want.pos.z)
          flag_mismatch($sformatf("out_z %0d, want %0d", out_ch.out_z, want.pos.z));
        if (out_ch.out_intensity !== want.intensity)
          flag_mismatch($sformatf("out_intensity %0d, want %0d",
                                  out_ch.out_intensity, want.intensity));
        if (out_ch.out_time_ns !== want.time_ns)
          flag_mismatch($sformatf("out_time_ns %0d, want %0d",
                                  out_ch.out_time_ns, want.time_ns));
        if (out_ch.kept_index !== want.index)
          flag_mismatch($sformatf("kept_index %0d, want %0d",
                                  out_ch.kept_index, want.index));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_LINE_COUNT: line_cfg  = data[LINE_BITS-1:0];
      CFG_KEEP_EVERY: keep_cfg  = data[KEEP_BITS-1:0];
      CFG_BLIND_MM:   blind_cfg = data[BLIND_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until all items are in, all results out, and the pipe is empty
  task automatic settle();
    while (point_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (kept_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pt(input bit fs, input int x, input int y, input int z,
                         input logic [7:0] line, input logic [7:0] tag,
                         input logic [7:0] refl, input logic [31:0] offs);
    pt_item_t p;
    p.frame_start = fs;
    p.pos.x = 24'(x);
    p.pos.y = 24'(y);
    p.pos.z = 24'(z);
    p.line  = line;
    p.tag   = tag;
    p.refl  = refl;
    p.offs  = offs;
    point_backlog = {point_backlog, p};
  endtask

  function automatic pt_item_t make_point(input bit clean);
    pt_item_t p;
    int       c[3];
    int       b;
    int       a;
    int       mode;
    p.refl = 8'($urandom);
    p.offs = $urandom;
    if (!clean) begin
      p.frame_start = ($urandom_range(0, 3) == 0);
      p.pos  = {24'($urandom), 24'($urandom), 24'($urandom)};
      p.line = 8'($urandom);
      p.tag  = 8'($urandom);
      return p;
    end
    p.frame_start = 1'b0;
    mode = $urandom_range(0, 9);
    b = int'(blind_cfg);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        5, 6, 7: c[i] = int'($urandom_range(0, 2)) - 1;
        8: begin
          case ($urandom_range(0, 3))
            0: c[i] = 8388607;
            1: c[i] = -8388608;
            2: c[i] = 0;
            default: c[i] = -1;
          endcase
        end
        9: c[i] = int'($urandom_range(0, 4000)) - 2000;
        default: c[i] = $urandom;
      endcase
    end
    if (mode >= 5 && mode <= 7) begin
      // one axis close to the blind radius
      a = $urandom_range(0, 2);
      c[a] = int'($urandom_range(0, 2 * b + 8)) - b - 4;
    end
    p.pos = {24'(c[0]), 24'(c[1]), 24'(c[2])};
    if ($urandom_range(0, 99) < 15) p.pos = prev_pos;
    prev_pos = p.pos;
    p.line = (line_cfg == '0) ? 8'($urandom) : 8'($urandom_range(0, line_cfg - 1));
    p.tag  = (8'($urandom) & ~TAG_QUAL_MASK) |
             ($urandom_range(0, 1) ? TAG_QUAL_LOW : TAG_QUAL_NONE);
    return p;
  endfunction

  task automatic fill_frames(input int n_items, input int len_lo, input int len_hi);
    pt_item_t p;
    int       done;
    int       len;
    done = 0;
    while (done < n_items) begin
      p = make_point(1'b0);
      p.frame_start = 1'b1;
      point_backlog = {point_backlog, p};
      len = $urandom_range(len_lo, len_hi);
      for (int i = 0; i < len && done < n_items; i++) begin
        p = make_point($urandom_range(0, 99) < 85);
        point_backlog = {point_backlog, p};
        done++;
      end
    end
  endtask

  task automatic random_phase(input int n_items, input int len_lo, input int len_hi,
                              input logic [LINE_BITS-1:0] line,
                              input logic [KEEP_BITS-1:0] keep,
                              input logic [BLIND_BITS-1:0] blind);
    write_reg(CFG_LINE_COUNT, {9'($urandom), line});
    write_reg(CFG_KEEP_EVERY, {8'($urandom), keep});
    write_reg(CFG_BLIND_MM, blind);
    fill_frames(n_items, len_lo, len_hi);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.frame_start  = 1'b0;
    in_ch.point_x      = '0;
    in_ch.point_y      = '0;
    in_ch.point_z      = '0;
    in_ch.scan_line    = '0;
    in_ch.quality_tag  = '0;
    in_ch.reflectivity = '0;
    in_ch.offset_ns    = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_LINE_COUNT;
    cfg_wdata          = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 4 lines, keep all, 500 mm blind radius
    push_pt(1, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_pt(0, 500, 0, 0, 0, 8'h00, 1, 1);
    push_pt(0, 0, -500, 0, 0, 8'h00, 1, 1);
    push_pt(0, 501, 0, 0, 0, 8'h00, 2, 2);
    push_pt(0, 501, 0, 0, 1, 8'h10, 3, 3);
    push_pt(0, 8388607, -8388608, 8388607, 3, 8'h1F, 8'hFF, 32'hFFFF_FFFF);
    push_pt(0, -8388608, -8388608, -8388608, 0, 8'hCF, 0, 0);
    push_pt(0, 1000, 1000, 1000, 0, 8'h20, 4, 4);
    push_pt(0, 1000, 1000, 1000, 0, 8'h30, 5, 5);
    push_pt(0, 1000, 1000, 1000, 0, 8'hF0, 6, 6);
    push_pt(0, 1000, 1000, 1000, 3, 8'hDF, 7, 7);
    push_pt(0, 2000, 0, 0, 4, 8'h00, 8, 8);
    push_pt(0, 2000, 0, 0, 8'hFF, 8'h00, 9, 9);
    push_pt(0, 2000, 0, 0, 8'h80, 8'h00, 9, 9);
    push_pt(0, 0, 0, -501, 2, 8'h00, 10, 10);
    push_pt(0, 0, 0, 0, 2, 8'h00, 11, 11);
    push_pt(0, 300, 300, 300, 1, 8'h10, 12, 12);
    push_pt(1, 0, 0, -501, 0, 8'h00, 13, 13);
    push_pt(0, 300, 300, 300, 1, 8'h10, 14, 14);
    settle();

    // no line passes; keep_every of zero behaves as one
    write_reg(CFG_KEEP_EVERY, 16'h0000);
    write_reg(CFG_LINE_COUNT, 16'h0000);
    push_pt(0, 5000, 0, 0, 0, 8'h00, 15, 15);
    push_pt(0, 6000, 0, 0, 0, 8'h00, 16, 16);
    settle();
    write_reg(CFG_LINE_COUNT, 16'hFFFF);
    write_reg(CFG_SPARE, 16'hABCD);
    push_pt(0, 7000, 0, 0, 126, 8'h00, 17, 17);
    settle();
    write_reg(CFG_KEEP_EVERY, 16'h0003);
    for (int i = 0; i < 4; i++) push_pt(0, 8000 + i, 1, 1, 126, 8'h10, 18, 18);
    settle();
    // raise, then lower the sampling period inside one frame
    write_reg(CFG_KEEP_EVERY, 16'h000A);
    for (int i = 0; i < 4; i++) push_pt(0, 9000 + i, 2, 2, 0, 8'h00, 19, 19);
    settle();
    write_reg(CFG_KEEP_EVERY, 16'h0002);
    push_pt(0, 9100, 3, 3, 0, 8'h00, 20, 20);
    settle();
    write_reg(CFG_KEEP_EVERY, 16'h0001);
    write_reg(CFG_BLIND_MM, 16'h0000);
    push_pt(1, 1, 0, 0, 0, 8'h00, 21, 21);
    push_pt(0, 0, 0, 0, 0, 8'h00, 22, 22);
    push_pt(0, 1, 0, 0, 0, 8'h00, 23, 23);
    settle();
    write_reg(CFG_BLIND_MM, 16'hFFFF);
    push_pt(0, 65535, 0, 0, 0, 8'h00, 24, 24);
    push_pt(0, 0, -65536, 0, 0, 8'h00, 25, 25);
    push_pt(0, 0, 0, -65535, 0, 8'h00, 26, 26);
    settle();

    random_phase(90, 4, 60, 7'd64, 8'd1, 16'($urandom_range(0, 2000)));
    settle();
    random_phase(80, 4, 60, 7'd1, 8'd2, 16'd0);
    settle();
    steady = 1'b1;
    random_phase(60, 4, 60, 7'($urandom_range(1, 64)), 8'($urandom_range(1, 4)),
                 16'($urandom));
    settle();
    fill_frames(60, 4, 60);
    settle();
    steady = 1'b0;
    random_phase(300, 280, 300, 7'd64, 8'd255, 16'd100);
    settle();
    random_phase(120, 4, 60, 7'($urandom_range(1, 64)), 8'($urandom_range(1, 3)),
                 16'($urandom_range(0, 4000)));
    settle();

    if (errors == 0 && kept_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lpf_pkg.sv
sv/lpf_if.sv
sv/lpf_range.sv
sv/lidar_point_filter_unit.sv
tb/sv/tb_top.sv
